>>> hw/rtl/i2p_pkg.sv
// Types, character codes and precedence function for the infix to postfix converter.
`default_nettype none

package i2p_pkg;

    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_POP,
        S_NEXT,
        S_SPACE
    } t_state;

    typedef enum logic [2:0] {
        K_FLUSH,
        K_DIGIT,
        K_OPEN,
        K_CLOSE,
        K_OP
    } t_kind;

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == C_PLUS || c == C_MINUS) begin
            r = 2'd1;
        end else if (c == C_STAR || c == C_SLASH) begin
            r = 2'd2;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/i2p_stack.sv
// Operator stack memory: one write port, one registered read port.
`default_nettype none

module i2p_stack #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter_core.sv
// Top level: shunting-yard infix to postfix converter with a memory-based operator stack.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   input   | i_in_valid / o_in_ready   | i_func, i_char_in
//   output  | o_out_valid / i_out_ready | o_char_out, o_last, o_overflow
//
// An item passes through accept, stack top read and decode, and each popped
// entry adds a pop and an emit step, as the stack read port is registered; a
// flush adds a space step for each entry after the first. One item is in
// work at a time. Reset empties the stack at once. A stalled output holds
// the sequencer in place; the output register lets the next item in while
// the final result of the previous one waits.
`default_nettype none

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_func,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_char_out,
    output logic            o_last,
    output logic            o_overflow
);

    import i2p_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state        r_state, n_state;
    t_kind         r_kind, n_kind;
    logic [7:0]    r_char;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_pop_char;
    logic          r_out_valid;
    logic [7:0]    r_char_out;
    logic          r_last;
    logic          r_ovf;

    logic          w_can_emit;
    logic          w_cont;
    logic          w_full;
    logic [7:0]    w_top;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;

    logic          w_emit;
    logic [7:0]    w_emit_char;
    logic          w_emit_last;
    logic          w_emit_ovf;
    logic          w_push;
    logic          w_dec;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_save_pop;

    i2p_stack #(
        .DEPTH(STACK_DEPTH),
        .AW   (AW)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (w_push),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(r_char),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_top)
    );

    assign w_can_emit = !r_out_valid || i_out_ready;
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_cnt_m2   = r_count - CW'(2);

    always_comb begin
        case (r_kind)
            K_FLUSH: w_cont = (r_count != '0);
            K_CLOSE: w_cont = (r_count != '0) && (w_top != C_LPAREN);
            K_OP:    w_cont = (r_count != '0) && (rank_of(r_char) <= rank_of(w_top));
            default: w_cont = 1'b0;
        endcase
    end

    always_comb begin
        if (i_func) begin
            n_kind = K_FLUSH;
        end else if (i_char_in >= C_ZERO && i_char_in <= C_NINE) begin
            n_kind = K_DIGIT;
        end else if (i_char_in == C_LPAREN) begin
            n_kind = K_OPEN;
        end else if (i_char_in == C_RPAREN) begin
            n_kind = K_CLOSE;
        end else begin
            n_kind = K_OP;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (r_kind == K_FLUSH && !w_cont) begin
                    n_state = S_IDLE;
                end else if (w_can_emit) begin
                    n_state = w_cont ? S_POP : S_IDLE;
                end
            end
            S_POP: n_state = S_NEXT;
            S_NEXT: begin
                if (w_can_emit) begin
                    if (!w_cont) begin
                        n_state = S_IDLE;
                    end else if (r_kind == K_FLUSH) begin
                        n_state = S_SPACE;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_SPACE: begin
                if (w_can_emit) begin
                    n_state = S_POP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_emit      = 1'b0;
        w_emit_char = C_SPACE;
        w_emit_last = 1'b0;
        w_emit_ovf  = 1'b0;
        w_push      = 1'b0;
        w_dec       = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_cnt_m1[AW-1:0];
        w_save_pop  = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_READ: w_rd_en = (r_count != '0);
            S_EVAL: begin
                case (r_kind)
                    K_FLUSH: begin
                        w_emit = w_cont && w_can_emit;
                    end
                    K_DIGIT: begin
                        w_emit      = w_can_emit;
                        w_emit_char = r_char;
                        w_emit_last = 1'b1;
                    end
                    default: begin
                        w_emit      = w_can_emit;
                        w_emit_last = !w_cont;
                        w_emit_ovf  = !w_cont && w_full && (r_kind != K_CLOSE);
                        if (w_can_emit && !w_cont) begin
                            if (r_kind == K_CLOSE) begin
                                w_dec = (r_count != '0);
                            end else begin
                                w_push = !w_full;
                            end
                        end
                    end
                endcase
            end
            S_POP: begin
                w_save_pop = 1'b1;
                w_dec      = 1'b1;
                w_rd_en    = (r_count > CW'(1));
                w_rd_addr  = w_cnt_m2[AW-1:0];
            end
            S_NEXT: begin
                w_emit      = w_can_emit;
                w_emit_char = r_pop_char;
                w_emit_last = !w_cont;
                if (w_can_emit && !w_cont) begin
                    if (r_kind == K_CLOSE) begin
                        w_dec = (r_count != '0);
                    end else if (r_kind == K_OP) begin
                        w_push = !w_full;
                    end
                end
            end
            S_SPACE: w_emit = w_can_emit;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CW'(1);
        end else if (w_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind <= n_kind;
            r_char <= i_char_in;
        end
        if (w_save_pop) begin
            r_pop_char <= w_top;
        end
        if (w_emit) begin
            r_char_out <= w_emit_char;
            r_last     <= w_emit_last;
            r_ovf      <= w_emit_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char_out;
    assign o_last      = r_last;
    assign o_overflow  = r_ovf;

endmodule

`default_nettype wire

>>> test/infix_to_postfix_converter_core_tb.sv
// Testbench for infix_to_postfix_converter_core: directed and random infix streams checked against a postfix predictor.
`default_nettype none

module infix_to_postfix_converter_core_tb;

    import i2p_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       overflow;
    } t_postfix_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_func = 1'b0;
    logic [7:0] i_char_in = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_char_out;
    logic       o_last;
    logic       o_overflow;

    t_postfix_char postfix_expected[$];
    logic [7:0]    op_stack_model[STACK_DEPTH];
    int            op_depth = 0;
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            in_gap_max = 10;
    int            out_gap_max = 10;
    logic [7:0]    binary_ops[4] = '{C_PLUS, C_MINUS, C_STAR, C_SLASH};

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_char_in  (i_char_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int precedence_of(input logic [7:0] c);
        if (c == C_PLUS || c == C_MINUS) begin
            return 1;
        end else if (c == C_STAR || c == C_SLASH) begin
            return 2;
        end
        return 0;
    endfunction

    function automatic void predict_postfix(input logic func, input logic [7:0] ch);
        logic [7:0]    emitted[$];
        logic          dropped;
        t_postfix_char entry;
        dropped = 1'b0;
        if (func) begin
            while (op_depth > 0) begin
                emitted.push_back(C_SPACE);
                emitted.push_back(op_stack_model[op_depth - 1]);
                op_depth--;
            end
        end else if (ch >= C_ZERO && ch <= C_NINE) begin
            emitted.push_back(ch);
        end else begin
            emitted.push_back(C_SPACE);
            if (ch == C_RPAREN) begin
                while (op_depth > 0 && op_stack_model[op_depth - 1] != C_LPAREN) begin
                    emitted.push_back(op_stack_model[op_depth - 1]);
                    op_depth--;
                end
                if (op_depth > 0) begin
                    op_depth--;
                end
            end else begin
                if (ch != C_LPAREN) begin
                    while (op_depth > 0 &&
                           precedence_of(ch) <= precedence_of(op_stack_model[op_depth - 1])) begin
                        emitted.push_back(op_stack_model[op_depth - 1]);
                        op_depth--;
                    end
                end
                if (op_depth < STACK_DEPTH) begin
                    op_stack_model[op_depth] = ch;
                    op_depth++;
                end else begin
                    dropped = 1'b1;
                end
            end
        end
        foreach (emitted[k]) begin
            entry.ch = emitted[k];
            entry.last = (k == emitted.size() - 1);
            entry.overflow = dropped;
            postfix_expected.push_back(entry);
        end
    endfunction

    task automatic send_infix_char(input logic func, input logic [7:0] ch);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func <= func;
        i_char_in <= ch;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
        predict_postfix(func, ch);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            send_infix_char(1'b0, text[k]);
        end
    endtask

    task automatic send_flush();
        send_infix_char(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_digit();
        send_infix_char(1'b0, C_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic wait_postfix_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (postfix_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_precedence();
        in_gap_max = 0;
        out_gap_max = 0;
        send_text("0+9*(1-2)/3");
        send_flush();
        send_text("7-8-9");
        send_flush();
        in_gap_max = 10;
        out_gap_max = 10;
        wait_postfix_drained();
    endtask

    task automatic test_parens_and_rank0();
        send_text("(1+2#)");
        send_infix_char(1'b0, 8'h00);
        send_infix_char(1'b0, 8'hFF);
        send_infix_char(1'b0, C_SPACE);
        send_flush();
        send_infix_char(1'b1, 8'h00);
        send_text("4*5)");
        send_flush();
    endtask

    task automatic test_stack_overflow();
        int fill;
        repeat (2) begin
            fill = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1);
            repeat (fill) send_infix_char(1'b0, C_LPAREN);
            send_infix_char(1'b0, C_PLUS);
            send_infix_char(1'b0, C_STAR);
            send_digit();
            send_infix_char(1'b0, C_MINUS);
            send_infix_char(1'b0, C_LPAREN);
            repeat ($urandom_range(1, 4)) send_infix_char(1'b0, C_RPAREN);
            send_flush();
        end
        wait_postfix_drained();
    endtask

    task automatic send_expression(input int operands);
        int open_count;
        open_count = 0;
        for (int t = 0; t < operands; t++) begin
            while ($urandom_range(0, 3) == 0 && open_count < STACK_DEPTH + 4) begin
                send_infix_char(1'b0, C_LPAREN);
                open_count++;
            end
            repeat ($urandom_range(1, 3)) send_digit();
            while (open_count > 0 && $urandom_range(0, 2) == 0) begin
                send_infix_char(1'b0, C_RPAREN);
                open_count--;
            end
            if (t != operands - 1) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_infix_char(1'b0, ($urandom_range(0, 1) == 0) ? CH_CARET : CH_HASH);
                end else begin
                    send_infix_char(1'b0, binary_ops[$urandom_range(0, 3)]);
                end
            end
        end
        while (open_count > 0 && $urandom_range(0, 4) != 0) begin
            send_infix_char(1'b0, C_RPAREN);
            open_count--;
        end
        send_flush();
    endtask

    task automatic test_random_expressions();
        int expressions;
        expressions = 0;
        while (items_sent < 300) begin
            in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            send_expression($urandom_range(1, 8));
            expressions++;
            if (expressions % 6 == 0) begin
                wait_postfix_drained();
            end
        end
        in_gap_max = 10;
        out_gap_max = 10;
    endtask

    task automatic test_noise();
        repeat (70) begin
            if ($urandom_range(0, 7) == 0) begin
                send_flush();
            end else begin
                case ($urandom_range(0, 3))
                    0: send_infix_char(1'b0, 8'($urandom_range(0, 255)));
                    1: send_infix_char(1'b0, ($urandom_range(0, 1) == 0) ? C_LPAREN : C_RPAREN);
                    2: send_infix_char(1'b0, binary_ops[$urandom_range(0, 3)]);
                    default: send_digit();
                endcase
            end
        end
        send_flush();
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin : check_postfix
        t_postfix_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (postfix_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer char=%h last=%b overflow=%b",
                                        o_char_out, o_last, o_overflow));
            end else begin
                want = postfix_expected.pop_front();
                if (o_char_out !== want.ch || o_last !== want.last ||
                    o_overflow !== want.overflow) begin
                    note_mismatch($sformatf(
                        "expected char=%h last=%b overflow=%b, got char=%h last=%b overflow=%b",
                        want.ch, want.last, want.overflow, o_char_out, o_last, o_overflow));
                end
            end
        end
    end

    initial begin : pace_output
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("infix_to_postfix_converter_core test failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_precedence();
        test_parens_and_rank0();
        test_stack_overflow();
        test_random_expressions();
        test_noise();
        wait_postfix_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && postfix_expected.size() == 0) begin
            $display("infix_to_postfix_converter_core test passed");
        end else begin
            $display("infix_to_postfix_converter_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
